### design/lspp_pkg.sv
// Shared widths, register indexes and sequencer states of the segment projection unit.
`timescale 1ns / 1ps
package lspp_pkg;

  localparam int unsigned COORD_W = 32;             // coordinate width
  localparam int unsigned DIFF_W  = COORD_W + 1;    // exact coordinate difference
  localparam int unsigned PROD_W  = 2 * DIFF_W;     // exact product of two differences
  localparam int unsigned SUM_W   = PROD_W + 1;     // sum of two products
  localparam int unsigned MAG_W   = PROD_W;         // magnitude of dot or cross product
  localparam int unsigned LEN_W   = DIFF_W;         // segment length, below 2^33
  localparam int unsigned DIST_W  = 32;             // saturated distance width
  localparam int unsigned CFG_AW  = 2;              // configuration register index width

  localparam logic [CFG_AW-1:0] CFG_START_X = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_START_Y = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_END_X   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_END_Y   = 2'd3;

  typedef enum logic [4:0] {
    ST_READY = 5'b00001,
    ST_DIFF  = 5'b00010,
    ST_SQR   = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_ROOT  = 5'b10000
  } seq_state_e;

endpackage

### design/lspp_div.sv
// Fully pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module lspp_div #(
  parameter int unsigned NUM_W = 66,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NUM_W-DEN_W-1:0] quot_o,
  output logic             ovf_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned Q_W = NUM_W - DEN_W;

  logic [Q_W:0]     vld_q;
  logic [DEN_W-1:0] rem_q  [Q_W+1];
  logic [Q_W-1:0]   low_q  [Q_W+1];
  logic [Q_W-1:0]   quot_q [Q_W+1];
  logic             ovf_q  [Q_W+1];
  logic [TAG_W-1:0] tag_q  [Q_W+1];

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-1:0], valid_i};
    end
  end

  // Entry stage: the upper numerator bits form the first partial remainder.
  // A quotient that does not fit in Q_W bits shows as an upper part not below the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[NUM_W-1 -: DEN_W];
      low_q[0]  <= num_i[Q_W-1:0];
      quot_q[0] <= '0;
      ovf_q[0]  <= (num_i[NUM_W-1 -: DEN_W] >= den_i);
      tag_q[0]  <= tag_i;
    end
  end

  // One compare and subtract per stage.
  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DEN_W:0] rext;
    logic [DEN_W:0] rsub;
    logic           ge;

    always_comb begin
      rext = {rem_q[k-1], low_q[k-1][Q_W-1]};
      rsub = rext - {1'b0, den_i};
      ge   = (rext >= {1'b0, den_i});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rsub[DEN_W-1:0] : rext[DEN_W-1:0];
        low_q[k]  <= {low_q[k-1][Q_W-2:0], 1'b0};
        quot_q[k] <= {quot_q[k-1][Q_W-2:0], ge};
        ovf_q[k]  <= ovf_q[k-1];
        tag_q[k]  <= tag_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quot_o  = quot_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign tag_o   = tag_q[Q_W];

endmodule

### design/line_segment_point_projection_unit.sv
// Top level of the segment projection unit: configuration, length sequencer and item pipeline.
// Pipeline: 4 arithmetic stages, a 34-stage divider pipeline and one output register; one item
// is taken in every cycle while the output is not stalled and the length sequencer is idle.
// After reset and after every configuration write the segment length is recomputed by a
// bit-serial square root: tready stays low while that sequencer runs.
// Reset clears the segment registers to zero and empties the pipeline.
`timescale 1ns / 1ps
module line_segment_point_projection_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lspp_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // query_x[31:0], query_y[63:32]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [103:0]                m_axis_tdata    // along_track[31:0], cross_track[63:32],
                                                      // segment_length[95:64], zero_length[96]
);

  import lspp_pkg::*;

  // Segment registers.
  logic signed [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_START_X: start_x_q <= cfg_wdata_i;
        CFG_START_Y: start_y_q <= cfg_wdata_i;
        CFG_END_X:   end_x_q   <= cfg_wdata_i;
        CFG_END_Y:   end_y_q   <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Length sequencer: differences, squares, sum, then one root bit per cycle.
  seq_state_e               state_q, state_d;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [PROD_W-1:0]        sqx_q, sqy_q;
  logic [MAG_W-1:0]         x_q, x_d, res_q, res_d, bit_q, bit_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [MAG_W-1:0]         root_try;
  logic signed [PROD_W-1:0] sqx_full, sqy_full;

  always_comb begin
    sqx_full = dx_q * dx_q;
    sqy_full = dy_q * dy_q;
    root_try = res_q + bit_q;
    state_d  = state_q;
    x_d      = x_q;
    res_d    = res_q;
    bit_d    = bit_q;
    len_d    = len_q;
    case (state_q)
      ST_READY: ;
      ST_DIFF:  state_d = ST_SQR;
      ST_SQR:   state_d = ST_SUM;
      ST_SUM: begin
        x_d     = sqx_q + sqy_q;
        res_d   = '0;
        bit_d   = {2'b01, {(MAG_W-2){1'b0}}};
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (x_q >= root_try) begin
          x_d   = x_q - root_try;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          len_d   = res_d[LEN_W-1:0];
          state_d = ST_READY;
        end
      end
      default: state_d = ST_DIFF;
    endcase
    if (cfg_we_i) begin
      state_d = ST_DIFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DIFF;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIFF) begin
      dx_q <= DIFF_W'(end_x_q) - DIFF_W'(start_x_q);
      dy_q <= DIFF_W'(end_y_q) - DIFF_W'(start_y_q);
    end
    if (state_q == ST_SQR) begin
      sqx_q <= sqx_full;
      sqy_q <= sqy_full;
    end
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
    len_q <= len_d;
  end

  // Pipeline advances whenever the output register is free or being emptied.
  logic adv;
  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && (state_q == ST_READY);

  // Stage 1: offsets of the query point from the segment start.
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic signed [DIFF_W-1:0] tx_q, ty_q;
  logic signed [COORD_W-1:0] qx, qy;

  assign qx = s_axis_tdata[31:0];
  assign qy = s_axis_tdata[63:32];

  // Stage 2: the four products; stage 3: dot and cross; stage 4: magnitudes.
  logic signed [PROD_W-1:0] p_txdx_q, p_tydy_q, p_txdy_q, p_tydx_q;
  logic signed [SUM_W-1:0]  dot_q, crs_q;
  logic [MAG_W-1:0]         nd_q, nc_q;
  logic                     pos_q;
  logic signed [SUM_W-1:0]  crs_abs;

  assign crs_abs = crs_q[SUM_W-1] ? -crs_q : crs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid && s_axis_tready;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q     <= DIFF_W'(qx) - DIFF_W'(start_x_q);
      ty_q     <= DIFF_W'(qy) - DIFF_W'(start_y_q);
      p_txdx_q <= tx_q * dx_q;
      p_tydy_q <= ty_q * dy_q;
      p_txdy_q <= tx_q * dy_q;
      p_tydx_q <= ty_q * dx_q;
      dot_q    <= SUM_W'(p_txdx_q) + SUM_W'(p_tydy_q);
      crs_q    <= SUM_W'(p_txdy_q) - SUM_W'(p_tydx_q);
      pos_q    <= !dot_q[SUM_W-1] && (dot_q != '0);
      nd_q     <= dot_q[SUM_W-1] ? '0 : dot_q[MAG_W-1:0];
      nc_q     <= crs_abs[MAG_W-1:0];
    end
  end

  // Division of both products by the segment length.
  localparam int unsigned Q_W = MAG_W - LEN_W;
  logic             dv_dot, dv_crs;
  logic [Q_W-1:0]   q_dot, q_crs;
  logic             ovf_dot, ovf_crs;
  logic [0:0]       pos_out;

  lspp_div #(.NUM_W(MAG_W), .DEN_W(LEN_W), .TAG_W(1)) u_div_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .num_i   (nd_q),
    .den_i   (len_q),
    .tag_i   (pos_q),
    .valid_o (dv_dot),
    .quot_o  (q_dot),
    .ovf_o   (ovf_dot),
    .tag_o   (pos_out)
  );

  lspp_div #(.NUM_W(MAG_W), .DEN_W(LEN_W), .TAG_W(1)) u_div_crs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .num_i   (nc_q),
    .den_i   (len_q),
    .tag_i   (1'b0),
    .valid_o (dv_crs),
    .quot_o  (q_crs),
    .ovf_o   (ovf_crs),
    .tag_o   ()
  );

  // Output stage: clamp, saturate and the zero-length case.
  logic              zero_len;
  logic [LEN_W-1:0]  along_c;
  logic [DIST_W-1:0] along_d, cross_d, length_d;
  logic [DIST_W-1:0] along_q, cross_q, length_q;
  logic              zero_q;

  always_comb begin
    zero_len = (len_q == '0);
    along_c  = (ovf_dot || (q_dot > len_q)) ? len_q : q_dot;
    along_d  = '0;
    if (pos_out[0]) begin
      along_d = along_c[LEN_W-1] ? '1 : along_c[DIST_W-1:0];
    end
    cross_d  = (ovf_crs || q_crs[Q_W-1]) ? '1 : q_crs[DIST_W-1:0];
    length_d = len_q[LEN_W-1] ? '1 : len_q[DIST_W-1:0];
    if (zero_len) begin
      along_d  = '0;
      cross_d  = '0;
      length_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_dot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      along_q  <= along_d;
      cross_q  <= cross_d;
      length_q <= length_d;
      zero_q   <= zero_len;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, zero_q, length_q, cross_q, along_q};

  // Input is taken only once the segment length is settled.
  a_ready_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_READY && !cfg_we_i) || (state_q == ST_READY))
    else $error("item taken while the segment length is being computed");

  // Both divider lanes carry the same items.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_dot == dv_crs)
    else $error("divider lanes out of step");

  // A zero-length segment gives zero distances.
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && zero_q) |-> (along_q == '0 && cross_q == '0 && length_q == '0))
    else $error("nonzero distance on a zero-length segment");

  // The along-track distance never exceeds the segment length.
  a_along_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (along_q <= length_q))
    else $error("along-track distance beyond segment length");

endmodule

### tb/lspp_checker.sv
// Checker for the segment projection unit: predicts each result and compares it on arrival.
`timescale 1ns / 1ps
module lspp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lspp_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // query_x[31:0], query_y[63:32]
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [103:0]                m_axis_tdata,   // along_track[31:0], cross_track[63:32],
                                                      // segment_length[95:64], zero_length[96]
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);
  import lspp_pkg::*;

  typedef struct packed {
    logic [31:0] along_track;
    logic [31:0] cross_track;
    logic [31:0] segment_length;
    logic        zero_length;
  } projection_t;

  logic [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  projection_t projections_due[$];

  assign pending_o = projections_due.size();

  function automatic logic [127:0] widen(input logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  function automatic logic [31:0] clip32(input logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Exact projection of one query point onto the current segment.
  function automatic projection_t project_point(input logic [31:0] qx, input logic [31:0] qy);
    logic signed [127:0] dx, dy, tx, ty, dot, crs;
    logic [127:0] len2, len, cand, quot, crs_mag;
    projection_t r;
    dx = widen(seg_end_x) - widen(seg_start_x);
    dy = widen(seg_end_y) - widen(seg_start_y);
    tx = widen(qx) - widen(seg_start_x);
    ty = widen(qy) - widen(seg_start_y);
    len2 = dx * dx + dy * dy;
    // Floor square root, bit by bit; the length stays below 2^35.
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (128'd1 << b);
      if (cand * cand <= len2) len = cand;
    end
    r = '0;
    if (len == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    dot = tx * dx + ty * dy;
    crs = tx * dy - ty * dx;
    crs_mag = (crs < 0) ? -crs : crs;
    if (dot > 0) begin
      quot = dot / len;
      // Clamp to the segment end before saturating.
      r.along_track = clip32((quot > len) ? len : quot);
    end
    r.cross_track = clip32(crs_mag / len);
    r.segment_length = clip32(len);
    return r;
  endfunction

  // Track the registers, queue predictions and compare results in one place.
  always @(posedge clk_i or negedge rst_ni) begin
    projection_t due, seen;
    if (!rst_ni) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_end_x <= '0;
      seg_end_y <= '0;
      projections_due.delete();
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        projections_due.push_back(project_point(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START_X: seg_start_x <= cfg_wdata_i;
          CFG_START_Y: seg_start_y <= cfg_wdata_i;
          CFG_END_X:   seg_end_x <= cfg_wdata_i;
          CFG_END_Y:   seg_end_y <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tdata[96]};
        if (projections_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = projections_due.pop_front();
          if (due.along_track !== seen.along_track)
            $display("%0t: along_track expected %h actual %h", $time,
                     due.along_track, seen.along_track);
          if (due.cross_track !== seen.cross_track)
            $display("%0t: cross_track expected %h actual %h", $time,
                     due.cross_track, seen.cross_track);
          if (due.segment_length !== seen.segment_length)
            $display("%0t: segment_length expected %h actual %h", $time,
                     due.segment_length, seen.segment_length);
          if (due.zero_length !== seen.zero_length)
            $display("%0t: zero_length expected %b actual %b", $time,
                     due.zero_length, seen.zero_length);
          if (due !== seen) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

### tb/tb.sv
// Stimulus and verdict for the segment projection unit testbench.
`timescale 1ns / 1ps
module tb;
  import lspp_pkg::*;

  typedef enum int {PT_FULL, PT_NEAR, PT_EDGE} point_kind_e;

  localparam int DRAIN_CYCLES = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_AW-1:0]   cfg_addr_i;
  logic [31:0]         cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [103:0]        m_axis_tdata;
  int unsigned         pending;
  int unsigned         fail_count;
  bit                  steady;      // no idling while set
  logic [31:0]         base_x, base_y;

  line_segment_point_projection_unit dut (.*);

  lspp_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  // Result side: a random stall before each item, none while steady is set.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_query(input logic [31:0] qx, input logic [31:0] qy);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {qy, qx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone idle.
  task automatic set_segment(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ex, input logic [31:0] ey);
    logic [31:0] vals [4];
    vals = '{sx, sy, ex, ey};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= CFG_AW'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    base_x = sx;
    base_y = sy;
  endtask

  function automatic logic [31:0] pick_coord(input point_kind_e kind, input logic [31:0] base);
    logic [31:0] edges [6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
    case (kind)
      PT_FULL: return $urandom;
      PT_NEAR: return base + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  task automatic random_queries(input int count);
    int roll;
    point_kind_e kind;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      kind = (roll < 55) ? PT_NEAR : (roll < 85) ? PT_FULL : PT_EDGE;
      send_query(pick_coord(kind, base_x), pick_coord(kind, base_y));
    end
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    steady = 1'b0;
    base_x = '0;
    base_y = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-length segment straight out of reset.
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h0, 32'h0);

    // Segment along x, 0xA0000 long: before the start, on it, past the end.
    set_segment(32'h0, 32'h0, 32'h000A_0000, 32'h0);
    send_query(32'hFFFB_0000, 32'h0003_0000);
    send_query(32'h0, 32'h0);
    send_query(32'h0004_8000, 32'hFFFE_0000);
    send_query(32'h000A_0000, 32'h0);
    send_query(32'h0014_0000, 32'h0001_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);

    // Diagonal across the whole range: the length saturates, and so does the along-track distance at the end.
    set_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h0, 32'h0);
    send_query(32'h8000_0000, 32'h8000_0000);

    // Zero length away from the origin, then a one-lsb vertical segment.
    set_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h0, 32'h0);
    set_segment(32'h0, 32'h0, 32'h0, 32'h1);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h0);
    send_query(32'h0, 32'h1);

    // Random phases: odd phases run without idling, some segments are random.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: set_segment($urandom, $urandom, $urandom, $urandom);
        1: set_segment(pick_coord(PT_NEAR, 32'h0), pick_coord(PT_NEAR, 32'h0),
                       pick_coord(PT_NEAR, 32'h0), pick_coord(PT_NEAR, 32'h0));
        2: set_segment(pick_coord(PT_EDGE, 32'h0), pick_coord(PT_EDGE, 32'h0),
                       pick_coord(PT_EDGE, 32'h0), pick_coord(PT_EDGE, 32'h0));
        default: begin
          base_x = $urandom;
          base_y = $urandom;
          set_segment(base_x, base_y, base_x + $urandom_range(0, 32'h0010_0000),
                      base_y - $urandom_range(0, 32'h0010_0000));
        end
      endcase
      steady = ph[0];
      random_queries(75);
      // Let everything drain mid-phase before carrying on.
      drain();
      random_queries(75);
    end
    steady = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
